FILE: hw/rtl/kspn_pkg.sv
// Shared types, codes, constants and helper functions of the keyed SPN block cipher.
package kspn_pkg;

	localparam int ROUNDS    = 16;
	localparam int NUM_BYTES = 16;
	localparam int NUM_NYB   = 32;

	// Configuration register indexes and reset values
	localparam logic       REG_PERMUTE_PERIOD   = 1'b0;
	localparam logic [4:0] PERMUTE_PERIOD_RESET = 5'd2;

	// Operation codes of an input transaction
	typedef enum logic [2:0] {
		OP_LOAD_SUB  = 3'd0,
		OP_LOAD_PERM = 3'd1,
		OP_LOAD_KEY  = 3'd2,
		OP_ENCRYPT   = 3'd3,
		OP_DECRYPT   = 3'd4
	} op_t;

	// Byte 0 is the most significant byte; nybble 2k is the high nybble of byte k
	typedef logic [0:NUM_BYTES-1][7:0] blk_t;
	typedef logic [0:NUM_NYB-1][3:0]   nyb_t;

	// Table write controls fanned out to every lane
	typedef struct packed {
		logic       sbox_we;
		logic       key_we;
		logic [7:0] index;
		logic [7:0] value;
	} lane_wr_t;

	// Round controls for the merging stage
	typedef struct packed {
		logic dir;
		logic permute;
		logic slide;
	} mix_ctl_t;

	// Build, per period, the mask of rounds that take the nybble permutation
	function automatic logic [31:0][15:0] build_masks();
		logic [31:0][15:0] m;
		int r;
		m = '0;
		for (int p = 1; p < 32; p++) begin
			for (int k = 1; k < ROUNDS; k++) begin
				r = p * k;
				if (r < ROUNDS && (r % 4) != 0) begin
					m[p][r] = 1'b1;
				end
			end
		end
		return m;
	endfunction

	localparam logic [31:0][15:0] PERM_MASKS = build_masks();

	// Forward chained XOR slide: running XOR, then byte 0 takes the XOR of all other bytes
	function automatic blk_t slide_fwd(blk_t b);
		blk_t c;
		logic [7:0] acc;
		for (int k = 0; k < NUM_BYTES; k++) begin
			acc = '0;
			for (int i = 0; i < NUM_BYTES; i++) begin
				if ((k == 0 && i != 0) || (k != 0 && i <= k)) begin
					acc = acc ^ b[i];
				end
			end
			c[k] = acc;
		end
		return c;
	endfunction

	// Backward chained XOR slide
	function automatic blk_t slide_bwd(blk_t b);
		blk_t c;
		c[0] = b[0] ^ b[NUM_BYTES-1];
		c[1] = b[1] ^ b[0] ^ b[NUM_BYTES-1];
		for (int i = 2; i < NUM_BYTES; i++) begin
			c[i] = b[i] ^ b[i-1];
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/keyed_spn_block_cipher.sv
// Top level of the keyed SPN block cipher: transaction control, lanes, merging stage, config.
//
// A 128-bit keyed substitution-permutation cipher with sixteen byte lanes that each hold a
// copy of the substitution table and its inverse. Encrypt and decrypt run one round per
// cycle, bounded by the single read port of each lane's substitution memory; round 16 never
// permutes, so its slide and key XOR fold into the first read or the result capture, and
// the next block starts in the cycle its predecessor's result is registered. Loads of the
// substitution, permutation and round key are written, and unused op codes dropped, once
// the core is free; transactions are processed strictly in order. One input transaction is
// held while the core works, a finished block waits in the core and one result waits in the
// output register; a stalled output stops the input once all three are full. Tables have no
// reset and must be loaded before use; permute_period resets to 2 and must be written through
// the APB port at byte address 0 while the block is idle, which the block does not enforce.
module keyed_spn_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  index,
	input  logic [7:0]  value,
	input  logic [63:0] block_hi,
	input  logic [63:0] block_lo,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_hi,
	output logic [63:0] out_lo,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Input holding register
	logic           in_valid_q;
	logic [2:0]     in_op_q;
	logic [7:0]     in_index_q;
	logic [7:0]     in_value_q;
	kspn_pkg::blk_t in_blk_q;

	// Core control
	logic       busy_q;
	logic       fin_q;
	logic       dir_q;
	logic [3:0] cnt_q;
	logic [4:0] period_q;

	// Output register
	logic        out_valid_q;
	logic [63:0] out_hi_q;
	logic [63:0] out_lo_q;

	logic               accept;
	logic               take;
	logic               core_free;
	logic               out_load;
	logic               start;
	logic               start_dir;
	logic               sub_take;
	logic               key_take;
	logic               perm_we;
	logic               cfg_we;
	logic [3:0]         rnd;
	logic [3:0]         key_row;
	logic               rd_en;
	logic               rd_dir;
	kspn_pkg::lane_wr_t lane_wr [kspn_pkg::NUM_BYTES];
	kspn_pkg::mix_ctl_t mix_ctl;
	kspn_pkg::blk_t     rd_blk;
	kspn_pkg::blk_t     key_blk;
	kspn_pkg::blk_t     mix_out;
	kspn_pkg::blk_t     first_dec;
	kspn_pkg::blk_t     rd_addr;
	kspn_pkg::blk_t     fin_blk;

	// Handshake decisions
	assign out_load  = fin_q && (!out_valid_q || !out_stall);
	assign core_free = !busy_q && (!fin_q || out_load);
	assign take      = in_valid_q && core_free;
	assign in_stall  = in_valid_q && !take;
	assign accept    = in_valid && !in_stall;

	// Decode the held transaction
	always_comb begin
		start     = 1'b0;
		start_dir = 1'b0;
		sub_take  = 1'b0;
		key_take  = 1'b0;
		perm_we   = 1'b0;
		unique case (in_op_q)
			kspn_pkg::OP_LOAD_SUB:  sub_take = take;
			kspn_pkg::OP_LOAD_PERM: perm_we  = take && (in_index_q[7:5] == 3'd0);
			kspn_pkg::OP_LOAD_KEY:  key_take = take;
			kspn_pkg::OP_ENCRYPT:   start    = take;
			kspn_pkg::OP_DECRYPT: begin
				start     = take;
				start_dir = 1'b1;
			end
			default: start = 1'b0;
		endcase
	end

	// Fan table writes out to the lanes
	always_comb begin
		for (int n = 0; n < kspn_pkg::NUM_BYTES; n++) begin
			lane_wr[n].sbox_we = sub_take;
			lane_wr[n].key_we  = key_take && (in_index_q[3:0] == 4'(n));
			lane_wr[n].index   = in_index_q;
			lane_wr[n].value   = in_value_q;
		end
	end

	// Round number and key row; the last round's key is read while no rounds run
	assign rnd     = dir_q ? 4'(4'd0 - cnt_q) : cnt_q;
	assign key_row = busy_q ? (rnd - 4'd1) : 4'(kspn_pkg::ROUNDS - 1);
	assign rd_en   = start || busy_q;
	assign rd_dir  = busy_q ? dir_q : start_dir;

	assign mix_ctl.dir     = dir_q;
	assign mix_ctl.permute = kspn_pkg::PERM_MASKS[period_q][rnd];
	assign mix_ctl.slide   = (rnd[1:0] == 2'd0);

	// Select lane read addresses: block, last decrypt round, or merged round output
	assign first_dec = kspn_pkg::slide_bwd(in_blk_q ^ key_blk);
	assign rd_addr   = busy_q ? mix_out : (start_dir ? first_dec : in_blk_q);

	// Finish encrypt with the last round's slide and key, decrypt is already done
	assign fin_blk = dir_q ? rd_blk : (kspn_pkg::slide_fwd(rd_blk) ^ key_blk);

	for (genvar n = 0; n < kspn_pkg::NUM_BYTES; n++) begin : g_lane
		kspn_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr       (lane_wr[n]),
			.rd_en    (rd_en),
			.rd_dir   (rd_dir),
			.rd_addr  (rd_addr[n]),
			.key_row  (key_row),
			.sub_byte (rd_blk[n]),
			.key_byte (key_blk[n])
		);
	end

	kspn_mix u_mix (
		.clk        (clk),
		.perm_we    (perm_we),
		.perm_index (in_index_q[4:0]),
		.perm_value (in_value_q[4:0]),
		.ctl        (mix_ctl),
		.data_in    (rd_blk),
		.key_in     (key_blk),
		.data_out   (mix_out)
	);

	// Track the held input, the round counter and the pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q  <= 1'b0;
			busy_q      <= 1'b0;
			fin_q       <= 1'b0;
			dir_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				in_valid_q <= 1'b1;
			end else if (take) begin
				in_valid_q <= 1'b0;
			end
			if (out_load) begin
				fin_q <= 1'b0;
			end
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd1;
				dir_q  <= start_dir;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(kspn_pkg::ROUNDS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture input and result payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			in_op_q    <= op;
			in_index_q <= index;
			in_value_q <= value;
			in_blk_q   <= {block_hi, block_lo};
		end
		if (out_load) begin
			{out_hi_q, out_lo_q} <= fin_blk;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hi    = out_hi_q;
	assign out_lo    = out_lo_q;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready &&
			(paddr[2] == kspn_pkg::REG_PERMUTE_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= kspn_pkg::PERMUTE_PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= pwdata[4:0];
		end
	end

	assign prdata = (paddr[2] == kspn_pkg::REG_PERMUTE_PERIOD) ? {27'd0, period_q} : 32'd0;

`ifndef SYNTHESIS
	a_busy_fin_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && fin_q))
		else $error("rounds running while a result is pending");

	a_last_round_fin: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (cnt_q == 4'(kspn_pkg::ROUNDS - 1)) |=> fin_q && !busy_q)
		else $error("last round did not hand over a result");

	a_start_count: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && (cnt_q == 4'd1))
		else $error("block start did not begin the round count");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(sub_take || key_take || perm_we) |-> !busy_q && !start)
		else $error("table load while rounds are running");
`endif

endmodule

FILE: hw/rtl/kspn_lane.sv
// One byte lane: forward and inverse substitution memories and one column of round keys.
module kspn_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  kspn_pkg::lane_wr_t wr,
	input  logic              rd_en,
	input  logic              rd_dir,
	input  logic [7:0]        rd_addr,
	input  logic [3:0]        key_row,
	output logic [7:0]        sub_byte,
	output logic [7:0]        key_byte
);

	logic [7:0] fwd_mem [256];
	logic [7:0] inv_mem [256];
	logic [7:0] key_q   [16];
	logic [7:0] fwd_q;
	logic [7:0] inv_q;
	logic       sel_q;

	// Write both tables on a substitution load, read one of them per round
	always_ff @(posedge clk) begin
		if (wr.sbox_we) begin
			fwd_mem[wr.index] <= wr.value;
			inv_mem[wr.value] <= wr.index;
		end
		if (rd_en && !rd_dir) begin
			fwd_q <= fwd_mem[rd_addr];
		end
		if (rd_en && rd_dir) begin
			inv_q <= inv_mem[rd_addr];
		end
	end

	// Hold the direction of the last read to steer the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (rd_en) begin
			sel_q <= rd_dir;
		end
	end

	// Store key bytes for this lane, one per round
	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_q[wr.index[7:4]] <= wr.value;
		end
	end

	assign sub_byte = sel_q ? inv_q : fwd_q;
	assign key_byte = key_q[key_row];

endmodule

FILE: hw/rtl/kspn_mix.sv
// Merging stage: nybble permutation, XOR slide or neither across all lanes, plus round-key XOR.
module kspn_mix (
	input  logic               clk,
	input  logic               perm_we,
	input  logic [4:0]         perm_index,
	input  logic [4:0]         perm_value,
	input  kspn_pkg::mix_ctl_t ctl,
	input  kspn_pkg::blk_t     data_in,
	input  kspn_pkg::blk_t     key_in,
	output kspn_pkg::blk_t     data_out
);

	logic [4:0] perm_q  [kspn_pkg::NUM_NYB];
	logic [4:0] iperm_q [kspn_pkg::NUM_NYB];

	kspn_pkg::blk_t pre;
	kspn_pkg::blk_t mid;
	kspn_pkg::blk_t slid;
	kspn_pkg::nyb_t src;
	kspn_pkg::nyb_t dst;
	logic [4:0]     tbl [kspn_pkg::NUM_NYB];

	// Load the permutation and its inverse together
	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_q[perm_index]  <= perm_value;
			iperm_q[perm_value] <= perm_index;
		end
	end

	// Decrypt adds the key first, encrypt last
	assign pre  = ctl.dir ? (data_in ^ key_in) : data_in;
	assign slid = ctl.dir ? kspn_pkg::slide_bwd(pre) : kspn_pkg::slide_fwd(pre);
	assign src  = pre;

	// Scatter nybbles; the highest source wins a shared target, an unreached one is zero
	always_comb begin
		for (int i = 0; i < kspn_pkg::NUM_NYB; i++) begin
			tbl[i] = ctl.dir ? iperm_q[i] : perm_q[i];
		end
		for (int j = 0; j < kspn_pkg::NUM_NYB; j++) begin
			dst[j] = '0;
			for (int i = 0; i < kspn_pkg::NUM_NYB; i++) begin
				if (tbl[i] == 5'(j)) begin
					dst[j] = src[i];
				end
			end
		end
	end

	// Pick the diffusion step of this round
	always_comb begin
		if (ctl.permute) begin
			mid = dst;
		end else if (ctl.slide) begin
			mid = slid;
		end else begin
			mid = pre;
		end
	end

	assign data_out = ctl.dir ? mid : (mid ^ key_in);

endmodule
